@@ hdl/tkcs_pkg.sv @@
// tkcs_pkg: types, constants and helpers for the top-k cache swap selector
// used by the controller, the datapath and the top level
`default_nettype none
package tkcs_pkg;
  localparam int unsigned MaxSeq = 4096;
  localparam int unsigned MaxSel = 2048;
  localparam int unsigned MaxK   = 16;
  localparam int unsigned SeqW   = $clog2(MaxSeq);
  localparam int unsigned SelW   = $clog2(MaxSel);
  localparam int unsigned KW     = $clog2(MaxK);

  localparam logic [1:0]  ModeLoadScore = 2'd0;
  localparam logic [1:0]  ModeLoadPool  = 2'd1;
  localparam logic [1:0]  ModeRun       = 2'd2;
  localparam logic        RegK          = 1'b0;
  localparam logic        RegPoolCap    = 1'b1;
  localparam logic [15:0] NegInfRaw     = 16'hFF80;
  // one bit above the widest key so an unfilled low entry loses to any key
  localparam logic [16:0] KeyLowInit    = 17'h1FFFF;

  typedef struct packed {
    logic [1:0]         mode;
    logic [11:0]        position;
    logic [15:0]        score_raw;
    logic signed [31:0] token_index;
    logic signed [31:0] candidate_len;
    logic signed [31:0] selected_len;
    logic signed [31:0] pool_entry;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  out_position;
    logic [10:0] demote_slot;
    logic [11:0] promote_token;
    logic [4:0]  copy_count;
    logic        last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic            clear;      // reset top lists at run start
    logic            pool_rd;    // read pool slot at addr
    logic            score_rd;   // read score at addr
    logic            ins_low;    // insert fetched key into low list
    logic            ins_high;   // insert fetched key into high list
    logic            kill_score; // overwrite score at tok with -inf
    logic            pool_wr;    // write rank entry back to pool
    logic [SeqW-1:0] addr;
    logic [SeqW-1:0] id;
    logic [KW-1:0]   rank;
    logic [KW:0]     n;
  } dp_cmd_t;

  // order-preserving key, both zeros equal
  function automatic logic [15:0] order_key(input logic [15:0] raw);
    logic [15:0] r;
    if (raw[14:0] == 15'd0) r = 16'h8000;
    else if (raw[15]) r = ~raw;
    else r = raw ^ 16'h8000;
    return r;
  endfunction
endpackage
`default_nettype wire

@@ hdl/topk_cache_swap_selector.sv @@
// Top-k cache swap selector; modes 0 and 1 are loads. A run reads each cached
// slot and, if its token is a candidate, reads, kills and inserts its score; it
// then reads and inserts each candidate score, writes back one pool entry per
// swap and emits k results, one per cycle unless the output stalls; with a copy
// count of zero the scans and writeback are skipped. Single-port memories pace
// the scans. Input is stalled during a run and while a result waits.
// depends on tkcs_pkg, tkcs_ctrl, tkcs_datapath
`default_nettype none
module topk_cache_swap_selector (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire tkcs_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output tkcs_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [30:0]         cfg_data_i
);
  import tkcs_pkg::*;

  dp_cmd_t     cmd;
  logic [31:0] pool_q;
  logic [10:0] low_slot;
  logic [11:0] high_tok;
  logic        acc;

  assign acc = in_valid_i && !in_stall_o;

  tkcs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_o(cmd), .pool_q_i(pool_q), .low_slot_i(low_slot), .high_tok_i(high_tok)
  );

  tkcs_datapath u_dp (
    .clk_i, .rst_ni,
    .ld_score_i(acc && in_data_i.mode == ModeLoadScore),
    .ld_pool_i(acc && in_data_i.mode == ModeLoadPool),
    .ld_pos_i(in_data_i.position),
    .ld_score_raw_i(in_data_i.score_raw),
    .ld_token_i(in_data_i.token_index),
    .cmd_i(cmd), .pool_q_o(pool_q),
    .low_slot_o(low_slot), .high_tok_o(high_tok)
  );
endmodule
`default_nettype wire

@@ hdl/tkcs_datapath.sv @@
// tkcs_datapath: score and pool memories plus the two sorted top-k lists
// depends on tkcs_pkg
`default_nettype none
module tkcs_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                ld_score_i,
  input  wire logic                ld_pool_i,
  input  wire logic [11:0]         ld_pos_i,
  input  wire logic [15:0]         ld_score_raw_i,
  input  wire logic [31:0]         ld_token_i,
  input  wire tkcs_pkg::dp_cmd_t   cmd_i,
  output logic [31:0]              pool_q_o,
  output logic [10:0]              low_slot_o,
  output logic [11:0]              high_tok_o
);
  import tkcs_pkg::*;

  logic [15:0] score_mem [MaxSeq];
  logic [31:0] pool_mem  [MaxSel];
  logic [15:0] score_q;
  logic [31:0] pool_q;
  logic [16:0] low_key_q  [MaxK];
  logic [SelW-1:0] low_id_q [MaxK];
  logic [15:0] high_key_q [MaxK];
  logic [SeqW-1:0] high_id_q [MaxK];
  logic [15:0] key;
  logic [16:0] lkey;
  logic [SelW-1:0] low_id;

  // score memory: one write port (load or kill), one registered read
  always_ff @(posedge clk_i) begin
    if (ld_score_i) begin
      score_mem[ld_pos_i[SeqW-1:0]] <= ld_score_raw_i;
    end else if (cmd_i.kill_score) begin
      score_mem[cmd_i.addr] <= NegInfRaw;
    end
    if (cmd_i.score_rd) score_q <= score_mem[cmd_i.addr];
  end

  always_ff @(posedge clk_i) begin
    if (ld_pool_i && ld_pos_i < 12'(MaxSel)) begin
      pool_mem[ld_pos_i[SelW-1:0]] <= ld_token_i;
    end else if (cmd_i.pool_wr) begin
      pool_mem[low_id_q[cmd_i.rank]] <= 32'(high_id_q[cmd_i.rank]);
    end
    if (cmd_i.pool_rd) pool_q <= pool_mem[cmd_i.addr[SelW-1:0]];
  end

  assign key    = order_key(score_q);
  assign lkey   = {1'b0, key};
  assign low_id = cmd_i.id[SelW-1:0];

  // insertion into sorted lists: each entry compares against its own and left neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < MaxK; p++) begin
        low_key_q[p] <= KeyLowInit; low_id_q[p] <= '0;
        high_key_q[p] <= '0; high_id_q[p] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int p = 0; p < MaxK; p++) begin
        low_key_q[p] <= KeyLowInit; low_id_q[p] <= '0;
        high_key_q[p] <= '0; high_id_q[p] <= '0;
      end
    end else begin
      for (int p = 0; p < MaxK; p++) begin
        logic lb, lbp, hb, hbp;
        lb = (lkey < low_key_q[p]) ||
             (lkey == low_key_q[p] && low_id < low_id_q[p]);
        hb = (key > high_key_q[p]) ||
             (key == high_key_q[p] && cmd_i.id < high_id_q[p]);
        if (p == 0) begin
          lbp = 1'b0; hbp = 1'b0;
        end else begin
          lbp = (lkey < low_key_q[p-1]) ||
                (lkey == low_key_q[p-1] && low_id < low_id_q[p-1]);
          hbp = (key > high_key_q[p-1]) ||
                (key == high_key_q[p-1] && cmd_i.id < high_id_q[p-1]);
        end
        if (cmd_i.ins_low && (KW+1)'(p) < cmd_i.n && lb) begin
          if (lbp && p > 0) begin
            low_key_q[p] <= low_key_q[p-1]; low_id_q[p] <= low_id_q[p-1];
          end else begin
            low_key_q[p] <= lkey; low_id_q[p] <= low_id;
          end
        end
        if (cmd_i.ins_high && (KW+1)'(p) < cmd_i.n && hb) begin
          if (hbp && p > 0) begin
            high_key_q[p] <= high_key_q[p-1]; high_id_q[p] <= high_id_q[p-1];
          end else begin
            high_key_q[p] <= key; high_id_q[p] <= cmd_i.id;
          end
        end
      end
    end
  end

  assign pool_q_o   = pool_q;
  assign low_slot_o = low_id_q[cmd_i.rank];
  assign high_tok_o = high_id_q[cmd_i.rank];
endmodule
`default_nettype wire

@@ hdl/tkcs_ctrl.sv @@
// tkcs_ctrl: run sequencer and result register
// depends on tkcs_pkg
`default_nettype none
module tkcs_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire tkcs_pkg::in_item_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output tkcs_pkg::out_item_t     out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [30:0]        cfg_data_i,
  output tkcs_pkg::dp_cmd_t       cmd_o,
  input  wire logic [31:0]        pool_q_i,
  input  wire logic [10:0]        low_slot_i,
  input  wire logic [11:0]        high_tok_i
);
  import tkcs_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StLowRd, StLowWait, StLowTok, StLowKey,
    StHighRd, StHighKey, StWrite, StEmit
  } state_e;

  state_e          state_q;
  logic [4:0]      k_q;
  logic [30:0]     cap_q;
  logic [SeqW:0]   cand_q;
  logic [SelW:0]   sel_q;
  logic [SeqW:0]   cnt_q;
  logic [SeqW-1:0] tok_q;
  logic [KW:0]     copy_q, keff_q, rank_q;
  logic            oval_q;
  out_item_t       odat_q;
  logic            acc;
  logic [SeqW:0]   cand_c;
  logic [SelW:0]   sel_c;
  logic [KW:0]     keff_c, copy_c;
  logic [SeqW+1:0] avail;

  assign in_stall_o = (state_q != StIdle) || oval_q;
  assign acc = in_valid_i && !in_stall_o;

  always_comb begin
    cand_c = in_data_i.candidate_len[31] ? '0 :
             (in_data_i.candidate_len > 32'(MaxSeq)) ? (SeqW+1)'(MaxSeq) :
             in_data_i.candidate_len[SeqW:0];
    sel_c  = in_data_i.selected_len[31] ? '0 :
             (in_data_i.selected_len > 32'(MaxSel)) ? (SelW+1)'(MaxSel) :
             in_data_i.selected_len[SelW:0];
    keff_c = (k_q > 5'(MaxK)) ? (KW+1)'(MaxK) : k_q[KW:0];
    avail  = (cand_c > (SeqW+1)'(sel_c)) ? (SeqW+2)'(cand_c) - (SeqW+2)'(sel_c) : '0;
    copy_c = keff_c;
    if ((SelW+1)'(copy_c) > sel_c) copy_c = sel_c[KW:0];
    if ((SeqW+2)'(copy_c) > avail) copy_c = avail[KW:0];
    if (in_data_i.pool_entry[31] || in_data_i.pool_entry[30:0] >= cap_q ||
        cand_c == '0 || sel_c == '0) copy_c = '0;
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.n = copy_q;
    cmd_o.rank = rank_q[KW-1:0];
    cmd_o.clear = acc && in_data_i.mode == ModeRun;
    case (state_q)
      StLowRd: begin cmd_o.pool_rd = 1'b1; cmd_o.addr = cnt_q[SeqW-1:0]; end
      StLowTok: begin cmd_o.score_rd = 1'b1; cmd_o.addr = tok_q; end
      StLowKey: begin
        cmd_o.ins_low = 1'b1; cmd_o.kill_score = 1'b1;
        cmd_o.addr = tok_q; cmd_o.id = cnt_q[SeqW-1:0];
      end
      StHighRd: begin cmd_o.score_rd = 1'b1; cmd_o.addr = cnt_q[SeqW-1:0]; end
      StHighKey: begin cmd_o.ins_high = 1'b1; cmd_o.id = SeqW'(cnt_q - 1'b1); end
      StWrite: cmd_o.pool_wr = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; k_q <= 5'd1; cap_q <= 31'd1; oval_q <= 1'b0;
      cand_q <= '0; sel_q <= '0; cnt_q <= '0; tok_q <= '0;
      copy_q <= '0; keff_q <= '0; rank_q <= '0; odat_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegK) k_q <= cfg_data_i[4:0];
        else cap_q <= cfg_data_i;
      end
      if (oval_q && !out_stall_i) oval_q <= 1'b0;
      case (state_q)
        StIdle: if (acc && in_data_i.mode == ModeRun && keff_c != '0) begin
          cand_q <= cand_c; sel_q <= sel_c; copy_q <= copy_c; keff_q <= keff_c;
          cnt_q <= '0; rank_q <= '0;
          state_q <= (copy_c != '0) ? StLowRd : StEmit;
        end
        StLowRd:   state_q <= StLowWait;
        StLowWait: begin
          // skip tokens outside the candidate range
          if (pool_q_i[31] || pool_q_i >= 32'(cand_q)) begin
            cnt_q <= cnt_q + 1'b1;
            state_q <= ((SelW+1)'(cnt_q + 1'b1) == sel_q) ? StHighRd : StLowRd;
            if ((SelW+1)'(cnt_q + 1'b1) == sel_q) cnt_q <= '0;
          end else begin
            tok_q <= pool_q_i[SeqW-1:0];
            state_q <= StLowTok;
          end
        end
        StLowTok:  state_q <= StLowKey;
        StLowKey: begin
          if ((SelW+1)'(cnt_q + 1'b1) == sel_q) begin
            cnt_q <= '0; state_q <= StHighRd;
          end else begin
            cnt_q <= cnt_q + 1'b1; state_q <= StLowRd;
          end
        end
        StHighRd: begin cnt_q <= cnt_q + 1'b1; state_q <= StHighKey; end
        StHighKey: state_q <= (cnt_q == cand_q) ? StWrite : StHighRd;
        StWrite: begin
          if (rank_q + 1'b1 == copy_q) begin
            rank_q <= '0; state_q <= StEmit;
          end else rank_q <= rank_q + 1'b1;
        end
        StEmit: if (!oval_q || !out_stall_i) begin
          oval_q <= 1'b1;
          odat_q.out_position  <= rank_q[3:0];
          odat_q.demote_slot   <= (rank_q < copy_q) ? low_slot_i : '0;
          odat_q.promote_token <= (rank_q < copy_q) ? high_tok_i : '0;
          odat_q.copy_count    <= 5'(copy_q);
          odat_q.last          <= (rank_q + 1'b1 == keff_q);
          if (rank_q + 1'b1 == keff_q) state_q <= StIdle;
          else rank_q <= rank_q + 1'b1;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = oval_q;
  assign out_data_o  = odat_q;
endmodule
`default_nettype wire
